[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define SPTG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sptg assertion failed");

// next-cycle implication, off while reset is high
`define SPTG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sptg assertion failed");

// next-cycle implication, checked through reset as well
`define SPTG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sptg assertion failed");

`endif

[rtl/sptg_pkg.sv]
// Types and constants of the pan/tilt command guard
`default_nettype none

package sptg_pkg;

  typedef enum logic [2:0] {
    CMD_HELLO   = 3'd0,
    CMD_SET     = 3'd1,
    CMD_CENTER  = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_DISABLE = 3'd4,
    CMD_STATUS  = 3'd5,
    CMD_TICK    = 3'd6,
    CMD_IGNORED = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    CODE_NONE   = 3'd0,
    CODE_ACK    = 3'd1,
    CODE_READY  = 3'd2,
    CODE_STATUS = 3'd3,
    CODE_BADSEQ = 3'd4,
    CODE_STALE  = 3'd5,
    CODE_NOTEN  = 3'd6,
    CODE_RANGE  = 3'd7
  } code_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_ATTACH = 2'd2,
    ACT_DETACH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    WD_IDLE    = 2'd0,
    WD_ARMED   = 2'd1,
    WD_EXPIRED = 2'd2
  } wd_e;

  typedef enum logic [2:0] {
    REG_PAN_MIN    = 3'd0,
    REG_PAN_MAX    = 3'd1,
    REG_TILT_MIN   = 3'd2,
    REG_TILT_MAX   = 3'd3,
    REG_PAN_HOME   = 3'd4,
    REG_TILT_HOME  = 3'd5,
    REG_WD_TIMEOUT = 3'd6
  } reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  PAN_MIN_RST    = 8'd0;
  localparam logic [7:0]  PAN_MAX_RST    = 8'd180;
  localparam logic [7:0]  TILT_MIN_RST   = 8'd0;
  localparam logic [7:0]  TILT_MAX_RST   = 8'd180;
  localparam logic [7:0]  PAN_HOME_RST   = 8'd90;
  localparam logic [7:0]  TILT_HOME_RST  = 8'd90;
  localparam logic [15:0] WD_TIMEOUT_RST = 16'd1000;

  localparam logic signed [15:0] ARG_MAX = 16'sd180;
  localparam logic [15:0]        SEQ_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  pan_min;
    logic [7:0]  pan_max;
    logic [7:0]  tilt_min;
    logic [7:0]  tilt_max;
    logic [7:0]  pan_home;
    logic [7:0]  tilt_home;
    logic [15:0] wd_timeout;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [15:0]        seq;
    logic signed [15:0] pan_arg;
    logic signed [15:0] tilt_arg;
    logic [31:0]        now_ms;
  } req_t;

  typedef struct packed {
    code_e       code;
    cmd_e        acked_cmd;
    logic [15:0] reply_seq;
    action_e     action;
    logic [7:0]  pan_now;
    logic [7:0]  tilt_now;
    logic        enabled_now;
    wd_e         watchdog_now;
    logic        replayed;
  } reply_t;

  typedef struct packed {
    code_e      code;
    cmd_e       acked_cmd;
    logic [7:0] pan;
    logic [7:0] tilt;
  } cache_t;

endpackage

`default_nettype wire

[rtl/sptg_ifs.sv]
// Command and reply channel interfaces
`default_nettype none

interface sptg_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [15:0]        seq;
  logic signed [15:0] pan_arg;
  logic signed [15:0] tilt_arg;
  logic [31:0]        now_ms;

  modport source (output valid, cmd, seq, pan_arg, tilt_arg, now_ms, input ready);
  modport sink (input valid, cmd, seq, pan_arg, tilt_arg, now_ms, output ready);
endinterface

interface sptg_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  code;
  logic [2:0]  acked_cmd;
  logic [15:0] reply_seq;
  logic [1:0]  action;
  logic [7:0]  pan_now;
  logic [7:0]  tilt_now;
  logic        enabled_now;
  logic [1:0]  watchdog_now;
  logic        replayed;

  modport source (output valid, code, acked_cmd, reply_seq, action, pan_now, tilt_now,
                  enabled_now, watchdog_now, replayed, input ready);
  modport sink (input valid, code, acked_cmd, reply_seq, action, pan_now, tilt_now,
                enabled_now, watchdog_now, replayed, output ready);
endinterface

`default_nettype wire

[rtl/sptg_cfg_regs.sv]
// Configuration register file
`default_nettype none

module sptg_cfg_regs import sptg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_min    <= PAN_MIN_RST;
      cfg.pan_max    <= PAN_MAX_RST;
      cfg.tilt_min   <= TILT_MIN_RST;
      cfg.tilt_max   <= TILT_MAX_RST;
      cfg.pan_home   <= PAN_HOME_RST;
      cfg.tilt_home  <= TILT_HOME_RST;
      cfg.wd_timeout <= WD_TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_e'(wr_index))
        REG_PAN_MIN:    cfg.pan_min    <= wr_data[7:0];
        REG_PAN_MAX:    cfg.pan_max    <= wr_data[7:0];
        REG_TILT_MIN:   cfg.tilt_min   <= wr_data[7:0];
        REG_TILT_MAX:   cfg.tilt_max   <= wr_data[7:0];
        REG_PAN_HOME:   cfg.pan_home   <= wr_data[7:0];
        REG_TILT_HOME:  cfg.tilt_home  <= wr_data[7:0];
        REG_WD_TIMEOUT: cfg.wd_timeout <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sptg_core.sv]
// Guard state and per-command decision logic
`default_nettype none

module sptg_core import sptg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  req_t   item,
  input  logic   fire,
  output reply_t rply
);

  logic        enabled, enabled_next;
  logic [7:0]  pan_pos, pan_pos_next;
  logic [7:0]  tilt_pos, tilt_pos_next;
  wd_e         wd_mode, wd_mode_next;
  logic [31:0] wd_deadline, wd_deadline_next;
  logic        have_seq, have_seq_next;
  logic [15:0] prev_seq, prev_seq_next;
  cmd_e        prev_cmd, prev_cmd_next;
  logic [7:0]  prev_pan, prev_pan_next;
  logic [7:0]  prev_tilt, prev_tilt_next;
  logic        prev_set_ok, prev_set_ok_next;
  cache_t      cache, cache_next;
  logic        rej_valid, rej_valid_next;
  logic [15:0] rej_seq, rej_seq_next;
  logic [7:0]  rej_pan, rej_pan_next;
  logic [7:0]  rej_tilt, rej_tilt_next;
  logic        rej_range, rej_range_next;

  logic        args_legal;
  logic [7:0]  pa, ta;
  logic [15:0] seq_exp;
  logic        is_dup, is_next, args_match, rej_match;
  logic [31:0] wd_elapsed, wd_new;
  logic        commit, set_ok;

  assign args_legal = (item.pan_arg >= 16'sd0) && (item.pan_arg <= ARG_MAX) &&
                      (item.tilt_arg >= 16'sd0) && (item.tilt_arg <= ARG_MAX);
  assign pa = (item.cmd == CMD_SET) ? item.pan_arg[7:0] : 8'd0;
  assign ta = (item.cmd == CMD_SET) ? item.tilt_arg[7:0] : 8'd0;
  // sequence wraps from the top value to 1, never to 0
  assign seq_exp    = (prev_seq == SEQ_MAX) ? 16'd1 : prev_seq + 16'd1;
  assign is_dup     = have_seq && (item.seq == prev_seq);
  assign is_next    = have_seq && (item.seq == seq_exp);
  assign args_match = (item.cmd == prev_cmd) && (pa == prev_pan) && (ta == prev_tilt);
  assign rej_match  = (item.cmd == CMD_SET) && (pa == rej_pan) && (ta == rej_tilt);
  assign wd_elapsed = item.now_ms - wd_deadline;
  assign wd_new     = item.now_ms + {16'd0, cfg.wd_timeout};

  always_comb begin
    rply             = '0;
    commit           = 1'b0;
    set_ok           = 1'b0;
    enabled_next     = enabled;
    pan_pos_next     = pan_pos;
    tilt_pos_next    = tilt_pos;
    wd_mode_next     = wd_mode;
    wd_deadline_next = wd_deadline;
    have_seq_next    = have_seq;
    prev_seq_next    = prev_seq;
    prev_cmd_next    = prev_cmd;
    prev_pan_next    = prev_pan;
    prev_tilt_next   = prev_tilt;
    prev_set_ok_next = prev_set_ok;
    cache_next       = cache;
    rej_valid_next   = rej_valid;
    rej_seq_next     = rej_seq;
    rej_pan_next     = rej_pan;
    rej_tilt_next    = rej_tilt;
    rej_range_next   = rej_range;

    case (item.cmd)
      CMD_TICK: begin
        // deadline reached when the wrapped difference is in the lower half
        if (enabled && (wd_mode == WD_ARMED) && !wd_elapsed[31]) begin
          enabled_next = 1'b0;
          wd_mode_next = WD_EXPIRED;
          rply.action  = ACT_DETACH;
        end
      end
      CMD_IGNORED: ;
      default: begin
        if (item.seq == 16'd0) begin
          rply.code = CODE_BADSEQ;
        end else begin
          rply.reply_seq = item.seq;
          if (item.cmd == CMD_HELLO) begin
            rply.code      = CODE_READY;
            rej_valid_next = 1'b0;
            commit         = 1'b1;
          end else if ((item.cmd == CMD_SET) && !args_legal) begin
            rply.code = CODE_RANGE;
          end else if (is_dup) begin
            if (!args_match) begin
              rply.code = CODE_STALE;
            end else if ((item.cmd == CMD_SET) && prev_set_ok && !enabled) begin
              rply.code = CODE_NOTEN;
            end else if (((item.cmd == CMD_CENTER) || (item.cmd == CMD_ENABLE)) &&
                         !enabled) begin
              rply.code = CODE_NOTEN;
            end else if (item.cmd == CMD_STATUS) begin
              rply.code         = CODE_STATUS;
              rply.pan_now      = pan_pos;
              rply.tilt_now     = tilt_pos;
              rply.enabled_now  = enabled;
              rply.watchdog_now = wd_mode;
            end else begin
              // replay from cache; an accepted SET also rearms the watchdog
              if ((item.cmd == CMD_SET) && prev_set_ok) begin
                wd_mode_next     = WD_ARMED;
                wd_deadline_next = wd_new;
              end
              rply.code      = cache.code;
              rply.acked_cmd = cache.acked_cmd;
              rply.pan_now   = cache.pan;
              rply.tilt_now  = cache.tilt;
              rply.replayed  = 1'b1;
            end
          end else if (rej_valid && (item.seq == rej_seq) && !is_next) begin
            if (!rej_match) rply.code = CODE_STALE;
            else            rply.code = rej_range ? CODE_RANGE : CODE_NOTEN;
          end else if (!is_next) begin
            rply.code = CODE_BADSEQ;
          end else begin
            commit = 1'b1;
            case (item.cmd)
              CMD_SET: begin
                if ((pa < cfg.pan_min) || (pa > cfg.pan_max) ||
                    (ta < cfg.tilt_min) || (ta > cfg.tilt_max)) begin
                  rply.code = CODE_RANGE;
                end else if (!enabled) begin
                  rply.code = CODE_NOTEN;
                end else begin
                  set_ok           = 1'b1;
                  pan_pos_next     = pa;
                  tilt_pos_next    = ta;
                  wd_mode_next     = WD_ARMED;
                  wd_deadline_next = wd_new;
                  rply.code        = CODE_ACK;
                  rply.acked_cmd   = CMD_SET;
                  rply.action      = ACT_WRITE;
                  rply.pan_now     = pa;
                  rply.tilt_now    = ta;
                end
              end
              CMD_CENTER: begin
                if (!enabled) begin
                  rply.code = CODE_NOTEN;
                end else begin
                  pan_pos_next   = cfg.pan_home;
                  tilt_pos_next  = cfg.tilt_home;
                  rply.code      = CODE_ACK;
                  rply.acked_cmd = CMD_CENTER;
                  rply.action    = ACT_WRITE;
                  rply.pan_now   = cfg.pan_home;
                  rply.tilt_now  = cfg.tilt_home;
                end
              end
              CMD_ENABLE: begin
                enabled_next     = 1'b1;
                pan_pos_next     = cfg.pan_home;
                tilt_pos_next    = cfg.tilt_home;
                wd_mode_next     = WD_ARMED;
                wd_deadline_next = wd_new;
                rply.code        = CODE_ACK;
                rply.acked_cmd   = CMD_ENABLE;
                rply.action      = ACT_ATTACH;
                rply.pan_now     = cfg.pan_home;
                rply.tilt_now    = cfg.tilt_home;
              end
              CMD_DISABLE: begin
                enabled_next     = 1'b0;
                wd_mode_next     = WD_IDLE;
                wd_deadline_next = 32'd0;
                rply.code        = CODE_ACK;
                rply.acked_cmd   = CMD_DISABLE;
                rply.action      = ACT_DETACH;
                rply.pan_now     = pan_pos;
                rply.tilt_now    = tilt_pos;
              end
              default: begin
                rply.code         = CODE_STATUS;
                rply.pan_now      = pan_pos;
                rply.tilt_now     = tilt_pos;
                rply.enabled_now  = enabled;
                rply.watchdog_now = wd_mode;
              end
            endcase
          end
        end
      end
    endcase

    // record the newly accepted sequence and its reply
    if (commit) begin
      if (rej_valid && (item.seq == rej_seq)) rej_valid_next = 1'b0;
      have_seq_next    = 1'b1;
      prev_seq_next    = item.seq;
      prev_cmd_next    = item.cmd;
      prev_pan_next    = pa;
      prev_tilt_next   = ta;
      prev_set_ok_next = set_ok;
      cache_next       = '{code: rply.code, acked_cmd: rply.acked_cmd,
                           pan: rply.pan_now, tilt: rply.tilt_now};
      if ((item.cmd == CMD_SET) && !set_ok) begin
        rej_valid_next = 1'b1;
        rej_seq_next   = item.seq;
        rej_pan_next   = pa;
        rej_tilt_next  = ta;
        rej_range_next = (rply.code == CODE_RANGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      pan_pos     <= PAN_HOME_RST;
      tilt_pos    <= TILT_HOME_RST;
      wd_mode     <= WD_IDLE;
      wd_deadline <= 32'd0;
      have_seq    <= 1'b0;
      prev_seq    <= 16'd0;
      prev_cmd    <= CMD_HELLO;
      prev_pan    <= 8'd0;
      prev_tilt   <= 8'd0;
      prev_set_ok <= 1'b0;
      cache       <= '0;
      rej_valid   <= 1'b0;
      rej_seq     <= 16'd0;
      rej_pan     <= 8'd0;
      rej_tilt    <= 8'd0;
      rej_range   <= 1'b0;
    end else if (fire) begin
      enabled     <= enabled_next;
      pan_pos     <= pan_pos_next;
      tilt_pos    <= tilt_pos_next;
      wd_mode     <= wd_mode_next;
      wd_deadline <= wd_deadline_next;
      have_seq    <= have_seq_next;
      prev_seq    <= prev_seq_next;
      prev_cmd    <= prev_cmd_next;
      prev_pan    <= prev_pan_next;
      prev_tilt   <= prev_tilt_next;
      prev_set_ok <= prev_set_ok_next;
      cache       <= cache_next;
      rej_valid   <= rej_valid_next;
      rej_seq     <= rej_seq_next;
      rej_pan     <= rej_pan_next;
      rej_tilt    <= rej_tilt_next;
      rej_range   <= rej_range_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sequenced_pan_tilt_command_guard_top.sv]
// Top level of the sequenced pan/tilt command guard
//
//   Channel  Dir  Handshake       Carries
//   req      in   valid/ready     cmd, seq, pan_arg, tilt_arg, now_ms
//   rsp      out  valid/ready     code, acked_cmd, reply_seq, action, pan_now,
//                                 tilt_now, enabled_now, watchdog_now, replayed
//   wr_*     in   wr_en strobe    register index and data
//
// One item per cycle sustained while rsp.ready stays high.
// The item sits in an input register while the decision logic runs, and the
// reply lands in an output register as the guard state updates.
// A stalled reply holds the output register; the input register takes one more
// item and then drops ready until the reply drains. Reset is synchronous.
`default_nettype none

module sequenced_pan_tilt_command_guard_top import sptg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  sptg_req_if.sink              req,
  sptg_rsp_if.source            rsp
);

  cfg_t   cfg;
  req_t   in_item;
  logic   in_valid;
  reply_t rply;
  reply_t out_reply;
  logic   out_valid;
  logic   adv;

  assign adv       = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || adv;

  sptg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  sptg_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .fire (adv),
    .rply (rply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) in_valid <= 1'b1;
      else if (adv)               in_valid <= 1'b0;
      if (adv)            out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= '{cmd: cmd_e'(req.cmd), seq: req.seq, pan_arg: req.pan_arg,
                   tilt_arg: req.tilt_arg, now_ms: req.now_ms};
    end
    if (adv) out_reply <= rply;
  end

  assign rsp.valid        = out_valid;
  assign rsp.code         = out_reply.code;
  assign rsp.acked_cmd    = out_reply.acked_cmd;
  assign rsp.reply_seq    = out_reply.reply_seq;
  assign rsp.action       = out_reply.action;
  assign rsp.pan_now      = out_reply.pan_now;
  assign rsp.tilt_now     = out_reply.tilt_now;
  assign rsp.enabled_now  = out_reply.enabled_now;
  assign rsp.watchdog_now = out_reply.watchdog_now;
  assign rsp.replayed     = out_reply.replayed;

endmodule

`default_nettype wire

[rtl/sptg_checker.sv]
// Port-level checker for the command guard, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module sptg_checker import sptg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_code,
  input logic [15:0] rsp_reply_seq,
  input logic [1:0]  rsp_action,
  input logic        rsp_enabled_now,
  input logic [1:0]  rsp_watchdog_now,
  input logic        rsp_replayed
);

  `SPTG_ASSERT_NEXT_ALWAYS(a_rst_empties, clk, rst, !rsp_valid)
  `SPTG_ASSERT_NEXT(a_stall_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `SPTG_ASSERT_SAME(a_replay_no_action, clk, rst, rsp_valid && rsp_replayed,
                    rsp_action == ACT_NONE)
  `SPTG_ASSERT_SAME(a_none_no_seq, clk, rst, rsp_valid && (rsp_code == CODE_NONE),
                    (rsp_reply_seq == 16'd0) && !rsp_replayed)
  `SPTG_ASSERT_SAME(a_status_fields, clk, rst, rsp_valid && (rsp_code != CODE_STATUS),
                    !rsp_enabled_now && (rsp_watchdog_now == WD_IDLE))

endmodule

bind sequenced_pan_tilt_command_guard_top sptg_checker u_sptg_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_code         (rsp.code),
  .rsp_reply_seq    (rsp.reply_seq),
  .rsp_action       (rsp.action),
  .rsp_enabled_now  (rsp.enabled_now),
  .rsp_watchdog_now (rsp.watchdog_now),
  .rsp_replayed     (rsp.replayed)
);

`default_nettype wire

[tb/sptg_scoreboard_pkg.sv]
// Reply predictor and scoreboard for the pan/tilt command guard
package sptg_scoreboard_pkg;
  import sptg_pkg::*;

  class reply_scoreboard;
    // register copies
    logic [7:0]  pan_min, pan_max, tilt_min, tilt_max, pan_home, tilt_home;
    logic [15:0] wd_timeout;

    // guard state
    logic        enabled;
    logic [7:0]  pan_pos, tilt_pos;
    wd_e         wd_mode;
    logic [31:0] wd_deadline;
    logic        have_seq;
    logic [15:0] last_seq;
    cmd_e        last_cmd;
    logic [7:0]  last_pan, last_tilt;
    logic        last_set_ok;
    cache_t      cached;
    logic        rej_valid;
    logic [15:0] rej_seq;
    logic [7:0]  rej_pan, rej_tilt;
    logic        rej_range;

    reply_t expected_replies[$];
    int     failures;
    int     reported;
    int     checked;

    function new();
      pan_min     = PAN_MIN_RST;
      pan_max     = PAN_MAX_RST;
      tilt_min    = TILT_MIN_RST;
      tilt_max    = TILT_MAX_RST;
      pan_home    = PAN_HOME_RST;
      tilt_home   = TILT_HOME_RST;
      wd_timeout  = WD_TIMEOUT_RST;
      enabled     = 1'b0;
      pan_pos     = PAN_HOME_RST;
      tilt_pos    = TILT_HOME_RST;
      wd_mode     = WD_IDLE;
      wd_deadline = '0;
      have_seq    = 1'b0;
      last_seq    = '0;
      last_cmd    = CMD_HELLO;
      last_pan    = '0;
      last_tilt   = '0;
      last_set_ok = 1'b0;
      cached      = '0;
      rej_valid   = 1'b0;
      rej_seq     = '0;
      rej_pan     = '0;
      rej_tilt    = '0;
      rej_range   = 1'b0;
      failures    = 0;
      reported    = 0;
      checked     = 0;
    endfunction

    function void write_reg(reg_e idx, logic [15:0] value);
      case (idx)
        REG_PAN_MIN:    pan_min = value[7:0];
        REG_PAN_MAX:    pan_max = value[7:0];
        REG_TILT_MIN:   tilt_min = value[7:0];
        REG_TILT_MAX:   tilt_max = value[7:0];
        REG_PAN_HOME:   pan_home = value[7:0];
        REG_TILT_HOME:  tilt_home = value[7:0];
        REG_WD_TIMEOUT: wd_timeout = value;
        default: ;
      endcase
    endfunction

    // code and sequence only, every other field zero
    function reply_t plain(code_e c, logic [15:0] s);
      reply_t r;
      r = '0;
      r.code = c;
      r.reply_seq = s;
      return r;
    endfunction

    function reply_t ack(cmd_e c, logic [15:0] s, action_e a);
      reply_t r;
      r = plain(CODE_ACK, s);
      r.acked_cmd = c;
      r.action = a;
      r.pan_now = pan_pos;
      r.tilt_now = tilt_pos;
      return r;
    endfunction

    function reply_t replay(logic [15:0] s);
      reply_t r;
      r = plain(cached.code, s);
      r.acked_cmd = cached.acked_cmd;
      r.pan_now = cached.pan;
      r.tilt_now = cached.tilt;
      r.replayed = 1'b1;
      return r;
    endfunction

    function reply_t status_report(logic [15:0] s);
      reply_t r;
      r = plain(CODE_STATUS, s);
      r.pan_now = pan_pos;
      r.tilt_now = tilt_pos;
      r.enabled_now = enabled;
      r.watchdog_now = wd_mode;
      return r;
    endfunction

    function void arm(logic [31:0] now);
      wd_mode = WD_ARMED;
      wd_deadline = now + {16'd0, wd_timeout};
    endfunction

    function logic [15:0] seq_after(logic [15:0] s);
      return (s == SEQ_MAX) ? 16'd1 : s + 16'd1;
    endfunction

    function void remember(logic [15:0] s, cmd_e c, logic [7:0] p, logic [7:0] t,
                           reply_t r);
      if (rej_valid && s == rej_seq)
        rej_valid = 1'b0;
      have_seq = 1'b1;
      last_seq = s;
      last_cmd = c;
      last_pan = p;
      last_tilt = t;
      last_set_ok = (c == CMD_SET) && (r.action == ACT_WRITE);
      cached.code = r.code;
      cached.acked_cmd = r.acked_cmd;
      cached.pan = r.pan_now;
      cached.tilt = r.tilt_now;
      if (c == CMD_SET && !last_set_ok) begin
        rej_valid = 1'b1;
        rej_seq = s;
        rej_pan = p;
        rej_tilt = t;
        rej_range = (r.code == CODE_RANGE);
      end
    endfunction

    function reply_t predict_reply(req_t q);
      logic signed [15:0] pan_s, tilt_s;
      logic [7:0]         pa, ta;
      logic [31:0]        past;
      reply_t             r;
      pan_s = q.pan_arg;
      tilt_s = q.tilt_arg;
      pa = '0;
      ta = '0;
      if (q.cmd == CMD_TICK) begin
        r = plain(CODE_NONE, '0);
        past = q.now_ms - wd_deadline;
        // deadline counts as reached while now is less than half the clock range past it
        if (enabled && wd_mode == WD_ARMED && past < 32'h8000_0000) begin
          enabled = 1'b0;
          wd_mode = WD_EXPIRED;
          r.action = ACT_DETACH;
        end
        return r;
      end
      if (q.cmd == CMD_IGNORED)
        return plain(CODE_NONE, '0);
      if (q.seq == '0)
        return plain(CODE_BADSEQ, '0);
      if (q.cmd == CMD_HELLO) begin
        r = plain(CODE_READY, q.seq);
        rej_valid = 1'b0;
        remember(q.seq, CMD_HELLO, '0, '0, r);
        return r;
      end
      if (q.cmd == CMD_SET) begin
        if (pan_s < 0 || pan_s > ARG_MAX || tilt_s < 0 || tilt_s > ARG_MAX)
          return plain(CODE_RANGE, q.seq);
        pa = pan_s[7:0];
        ta = tilt_s[7:0];
      end
      if (have_seq && q.seq == last_seq) begin
        if (q.cmd != last_cmd || pa != last_pan || ta != last_tilt)
          return plain(CODE_STALE, q.seq);
        if (q.cmd == CMD_SET) begin
          if (!last_set_ok)
            return replay(q.seq);
          if (!enabled)
            return plain(CODE_NOTEN, q.seq);
          arm(q.now_ms);
          return replay(q.seq);
        end
        if ((q.cmd == CMD_CENTER || q.cmd == CMD_ENABLE) && !enabled)
          return plain(CODE_NOTEN, q.seq);
        if (q.cmd == CMD_STATUS)
          return status_report(q.seq);
        return replay(q.seq);
      end
      // retry of the rejected SET, unless its number is the one due next
      if (rej_valid && q.seq == rej_seq && !(have_seq && q.seq == seq_after(last_seq))) begin
        if (q.cmd != CMD_SET || pa != rej_pan || ta != rej_tilt)
          return plain(CODE_STALE, q.seq);
        if (rej_range)
          return plain(CODE_RANGE, q.seq);
        return plain(CODE_NOTEN, q.seq);
      end
      if (!have_seq || q.seq != seq_after(last_seq))
        return plain(CODE_BADSEQ, q.seq);
      case (q.cmd)
        CMD_SET: begin
          if (pa < pan_min || pa > pan_max || ta < tilt_min || ta > tilt_max) begin
            r = plain(CODE_RANGE, q.seq);
          end else if (!enabled) begin
            r = plain(CODE_NOTEN, q.seq);
          end else begin
            pan_pos = pa;
            tilt_pos = ta;
            arm(q.now_ms);
            r = ack(CMD_SET, q.seq, ACT_WRITE);
          end
        end
        CMD_CENTER: begin
          if (!enabled) begin
            r = plain(CODE_NOTEN, q.seq);
          end else begin
            pan_pos = pan_home;
            tilt_pos = tilt_home;
            r = ack(CMD_CENTER, q.seq, ACT_WRITE);
          end
        end
        CMD_ENABLE: begin
          enabled = 1'b1;
          pan_pos = pan_home;
          tilt_pos = tilt_home;
          arm(q.now_ms);
          r = ack(CMD_ENABLE, q.seq, ACT_ATTACH);
        end
        CMD_DISABLE: begin
          enabled = 1'b0;
          wd_mode = WD_IDLE;
          wd_deadline = '0;
          r = ack(CMD_DISABLE, q.seq, ACT_DETACH);
        end
        default: r = status_report(q.seq);
      endcase
      remember(q.seq, q.cmd, pa, ta, r);
      return r;
    endfunction

    function void note_command(req_t q);
      expected_replies.push_back(predict_reply(q));
    endfunction

    function string show(reply_t r);
      return $sformatf("code=%0d acked=%0d seq=%0d act=%0d pan=%0d tilt=%0d en=%0d wd=%0d rep=%0d",
                       r.code, r.acked_cmd, r.reply_seq, r.action, r.pan_now, r.tilt_now,
                       r.enabled_now, r.watchdog_now, r.replayed);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      string  bad;
      checked++;
      if (expected_replies.size() == 0) begin
        failures++;
        if (reported < 10)
          $display("reply %0d with none expected: %s", checked, show(got));
        reported++;
        return;
      end
      want = expected_replies.pop_front();
      bad = "";
      if (got.code !== want.code) bad = {bad, " code"};
      if (got.acked_cmd !== want.acked_cmd) bad = {bad, " acked_cmd"};
      if (got.reply_seq !== want.reply_seq) bad = {bad, " reply_seq"};
      if (got.action !== want.action) bad = {bad, " action"};
      if (got.pan_now !== want.pan_now) bad = {bad, " pan_now"};
      if (got.tilt_now !== want.tilt_now) bad = {bad, " tilt_now"};
      if (got.enabled_now !== want.enabled_now) bad = {bad, " enabled_now"};
      if (got.watchdog_now !== want.watchdog_now) bad = {bad, " watchdog_now"};
      if (got.replayed !== want.replayed) bad = {bad, " replayed"};
      if (bad != "") begin
        failures++;
        if (reported < 10)
          $display("reply %0d wrong in%s\n  expected %s\n  actual   %s",
                   checked, bad, show(want), show(got));
        reported++;
      end
    endfunction
  endclass

endpackage

[tb/testbench.sv]
// Testbench for the pan/tilt command guard: directed and random commands against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sptg_pkg::*;
  import sptg_scoreboard_pkg::*;

  localparam int ITEMS_PER_PHASE = 90;
  localparam int NUM_PHASES      = 5;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_AT         = 250;
  localparam int HOLD_CYCLES     = 60;
  localparam int SETTLE          = 4;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  sptg_req_if req_ch ();
  sptg_rsp_if rsp_ch ();

  reply_scoreboard sb;
  bit              calm = 1'b0;
  logic [31:0]     clock_ms = 32'd5000;
  req_t            recent[$];
  int              quiet_cycles = 0;

  sequenced_pan_tilt_command_guard_top u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 21);
  endfunction

  task automatic send_cmd(req_t r);
    @(negedge clk);
    while (idle_now()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= r.cmd;
    req_ch.seq      <= r.seq;
    req_ch.pan_arg  <= r.pan_arg;
    req_ch.tilt_arg <= r.tilt_arg;
    req_ch.now_ms   <= r.now_ms;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_command(r);
    recent.push_back(r);
    if (recent.size() > 4)
      void'(recent.pop_front());
  endtask

  task automatic send(cmd_e c, logic [15:0] s, int p, int t, logic [31:0] now);
    req_t r;
    r.cmd = c;
    r.seq = s;
    r.pan_arg = p[15:0];
    r.tilt_arg = t[15:0];
    r.now_ms = now;
    send_cmd(r);
  endtask

  task automatic send_random();
    req_t r;
    int   roll;
    int   pick;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0)
      clock_ms += $urandom_range(0, 70000);
    else
      clock_ms += $urandom_range(0, 300);
    r.cmd = CMD_HELLO;
    r.seq = '0;
    r.pan_arg = '0;
    r.tilt_arg = '0;
    r.now_ms = clock_ms;
    if (!sb.have_seq || roll < 4) begin
      if ($urandom_range(0, 3) == 0)
        r.seq = SEQ_MAX - 16'($urandom_range(0, 3));
      else
        r.seq = 16'($urandom_range(0, 65535));
    end else if (roll < 66) begin
      // well-formed: the number due next
      r.seq = (sb.last_seq == SEQ_MAX) ? 16'd1 : sb.last_seq + 16'd1;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        r.cmd = CMD_SET;
        if ($urandom_range(0, 9) < 8) begin
          r.pan_arg = 16'($urandom_range(sb.pan_min, sb.pan_max));
          r.tilt_arg = 16'($urandom_range(sb.tilt_min, sb.tilt_max));
        end else begin
          r.pan_arg = 16'($urandom_range(0, 65535));
          r.tilt_arg = 16'($urandom_range(0, 65535));
        end
      end else if (pick < 47) begin
        r.cmd = CMD_ENABLE;
      end else if (pick < 57) begin
        r.cmd = CMD_CENTER;
      end else if (pick < 64) begin
        r.cmd = CMD_DISABLE;
      end else if (pick < 75) begin
        r.cmd = CMD_STATUS;
      end else begin
        r.cmd = CMD_TICK;
      end
    end else if (roll < 80 && recent.size() != 0) begin
      // retransmit a recent item, sometimes with an altered argument
      r = recent[$urandom_range(0, recent.size() - 1)];
      r.now_ms = clock_ms;
      if ($urandom_range(0, 2) == 0)
        r.tilt_arg[0] = ~r.tilt_arg[0];
    end else if (roll < 85) begin
      r.cmd = cmd_e'($urandom_range(0, 5));
      r.pan_arg = 16'($urandom_range(0, 180));
      r.tilt_arg = 16'($urandom_range(0, 180));
    end else begin
      r.cmd = cmd_e'($urandom_range(0, 7));
      r.seq = 16'($urandom_range(0, 65535));
      r.pan_arg = 16'($urandom_range(0, 65535));
      r.tilt_arg = 16'($urandom_range(0, 65535));
      r.now_ms = $urandom;
    end
    send_cmd(r);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(logic [7:0] pmin, logic [7:0] pmax, logic [7:0] tmin,
                           logic [7:0] tmax, logic [7:0] phome, logic [7:0] thome,
                           logic [15:0] timeout);
    write_reg(REG_PAN_MIN, {8'd0, pmin});
    write_reg(REG_PAN_MAX, {8'd0, pmax});
    write_reg(REG_TILT_MIN, {8'd0, tmin});
    write_reg(REG_TILT_MAX, {8'd0, tmax});
    write_reg(REG_PAN_HOME, {8'd0, phome});
    write_reg(REG_TILT_HOME, {8'd0, thome});
    write_reg(REG_WD_TIMEOUT, timeout);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // reply side: random stalls plus one long hold-off to back the block up
  initial begin
    bit held_off;
    held_off = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb.checked >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp_ch.ready <= !idle_now();
      end
    end
  end

  always @(posedge clk) begin
    reply_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.code         = code_e'(rsp_ch.code);
      got.acked_cmd    = cmd_e'(rsp_ch.acked_cmd);
      got.reply_seq    = rsp_ch.reply_seq;
      got.action       = action_e'(rsp_ch.action);
      got.pan_now      = rsp_ch.pan_now;
      got.tilt_now     = rsp_ch.tilt_now;
      got.enabled_now  = rsp_ch.enabled_now;
      got.watchdog_now = wd_e'(rsp_ch.watchdog_now);
      got.replayed     = rsp_ch.replayed;
      sb.check_reply(got);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.seq = '0;
    req_ch.pan_arg = '0;
    req_ch.tilt_arg = '0;
    req_ch.now_ms = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: sequence rules, argument limits, replays, watchdog expiry
    send(CMD_STATUS, 16'd5, 0, 0, 32'd0);
    send(CMD_HELLO, 16'd0, 0, 0, 32'd0);
    send(CMD_IGNORED, 16'd1234, -1, -1, 32'hFFFF_FFFF);
    send(CMD_HELLO, SEQ_MAX, 0, 0, 32'd0);
    send(CMD_SET, 16'd1, 10, 20, 32'd10);
    send(CMD_ENABLE, 16'd2, 0, 0, 32'd100);
    send(CMD_SET, 16'd1, 10, 20, 32'd110);
    send(CMD_SET, 16'd1, 11, 20, 32'd120);
    send(CMD_SET, 16'd3, -32768, 32767, 32'd150);
    send(CMD_SET, 16'd3, 0, 180, 32'd200);
    send(CMD_SET, 16'd3, 0, 180, 32'd300);
    send(CMD_SET, 16'd3, 1, 180, 32'd310);
    send(CMD_CENTER, 16'd4, 0, 0, 32'd400);
    send(CMD_STATUS, 16'd5, 0, 0, 32'd500);
    send(CMD_STATUS, 16'd5, 0, 0, 32'd600);
    send(CMD_TICK, 16'd0, 0, 0, 32'd1299);
    send(CMD_TICK, 16'd0, 0, 0, 32'd1300);
    send(CMD_CENTER, 16'd6, 0, 0, 32'd1400);
    send(CMD_CENTER, 16'd6, 0, 0, 32'd1410);
    send(CMD_DISABLE, 16'd7, 0, 0, 32'd1500);
    send(CMD_DISABLE, 16'd7, 0, 0, 32'd1510);
    send(CMD_ENABLE, 16'd8, 0, 0, 32'd2000);
    send(CMD_SET, 16'd9, 180, 0, 32'd2100);
    send(CMD_SET, 16'd10, 181, 0, 32'd2200);
    send(CMD_TICK, 16'hFFFF, 0, 0, 32'hFFFF_FFFF);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: configure(8'd20, 8'd160, 8'd30, 8'd150, 8'd100, 8'd80, 16'd300);
        1: configure(8'd0, 8'd180, 8'd0, 8'd180, 8'd0, 8'd180, 16'd1);
        // min above max: every SET fails the bounds
        2: configure(8'd120, 8'd60, 8'd0, 8'd180, 8'd180, 8'd0, 16'hFFFF);
        3: configure(8'd90, 8'd90, 8'd45, 8'd45, 8'd90, 8'd45,
                     16'($urandom_range(1, 2000)));
        default: begin
          clock_ms = 32'hFFFF_F000;
          configure(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                    8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                    8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                    16'($urandom_range(1, 3000)));
        end
      endcase
      calm = (ph == 2);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.expected_replies.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
